// ===== rtl/ookd_pkg.sv =====
package ookd_pkg;

   // Default sizes.
   localparam int DURATION_WIDTH_DEF = 24;
   localparam int MAX_CODE_BITS_DEF  = 32;

   // Fixed field widths.
   localparam int TIME_W = 16;
   localparam int PCT_W  = 7;
   localparam int BITS_W = 6;
   localparam int LEN_W  = 16;
   localparam int IDX_W  = 3;
   localparam int CODE_W = 32;
   localparam int STAT_W = 3;
   localparam int PROD_W = TIME_W + PCT_W;
   localparam int DEV_W  = TIME_W + 1;
   localparam int HI_W   = TIME_W + 2;
   localparam int QUEUE_DEPTH = 2;

   // Division by 100 as a reciprocal multiply; the estimate is low by at most one.
   localparam int DIV_SHIFT = PROD_W;
   localparam int DIV_MUL   = (1 << DIV_SHIFT) / 100;
   localparam int MUL_W     = PROD_W + DEV_W;

   // Reset values of the configuration registers.
   localparam logic [TIME_W-1:0] SHORT_TIME_RST = TIME_W'(350);
   localparam logic [TIME_W-1:0] LONG_TIME_RST  = TIME_W'(700);
   localparam logic [PCT_W-1:0]  PCT_RST        = PCT_W'(40);
   localparam logic [BITS_W-1:0] REQ_BITS_RST   = BITS_W'(24);
   localparam logic [BITS_W-1:0] MIN_VALID_RST  = BITS_W'(20);
   localparam logic [LEN_W-1:0]  MIN_LEN_RST    = LEN_W'(44);

   // Windows that follow from the reset values.
   localparam int SHORT_DEV_RST = (350 * 40) / 100;
   localparam int LONG_DEV_RST  = (700 * 40) / 100;
   localparam logic [TIME_W-1:0] SHORT_LO_RST = TIME_W'(350 - SHORT_DEV_RST);
   localparam logic [HI_W-1:0]   SHORT_HI_RST = HI_W'(350 + SHORT_DEV_RST);
   localparam logic [TIME_W-1:0] LONG_LO_RST  = TIME_W'(700 - LONG_DEV_RST);
   localparam logic [HI_W-1:0]   LONG_HI_RST  = HI_W'(700 + LONG_DEV_RST);

   typedef enum logic [IDX_W-1:0] {
      CSR_SHORT_TIME = 3'd0,
      CSR_LONG_TIME  = 3'd1,
      CSR_TOL_PCT    = 3'd2,
      CSR_REQ_BITS   = 3'd3,
      CSR_MIN_VALID  = 3'd4,
      CSR_MIN_LEN    = 3'd5
   } csr_index_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_SHORT    = 3'd1,
      STATUS_NEGPULSE = 3'd2,
      STATUS_BROKEN   = 3'd3,
      STATUS_ENDED    = 3'd4
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0] short_lo;
      logic [HI_W-1:0]   short_hi;
      logic [TIME_W-1:0] long_lo;
      logic [HI_W-1:0]   long_hi;
   } window_type;

   typedef struct packed {
      logic [BITS_W-1:0] req_bits;
      logic [BITS_W-1:0] min_valid;
   } decode_cfg_type;

   // One classified duration.
   typedef struct packed {
      logic first;
      logic last;
      logic neg;
      logic too_short;
      logic in_short;
      logic in_long;
   } item_type;

   typedef struct packed {
      logic              ok;
      logic [STAT_W-1:0] status;
      logic [CODE_W-1:0] code;
      logic [BITS_W-1:0] bits;
   } result_type;

   localparam int ITEM_W   = $bits(item_type);
   localparam int RESULT_W = $bits(result_type);

endpackage

// ===== rtl/ookd_fifo.sv =====
module ookd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/ookd_csr.sv =====
module ookd_csr
   import ookd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [TIME_W-1:0]    csr_data,
   output window_type           window,
   output decode_cfg_type       decode_cfg,
   output logic [LEN_W-1:0]     min_len,
   output logic                 busy
);

   logic [TIME_W-1:0] short_ff, long_ff;
   logic [PCT_W-1:0]  pct_ff;
   logic [BITS_W-1:0] req_bits_ff, min_valid_ff;
   logic [LEN_W-1:0]  min_len_ff;
   logic [1:0]        busy_cnt_ff, busy_cnt_in;

   logic [PROD_W-1:0] prod_s_ff, prod_l_ff;
   logic [DEV_W-1:0]  est_s_ff, est_l_ff;
   logic [MUL_W-1:0]  mul_s, mul_l;
   logic [DEV_W-1:0]  dev_s, dev_l;
   window_type        window_ff, window_in;
   logic              wr_en;

   // Exact floor(prod / 100) from an estimate that may be one low.
   function automatic logic [DEV_W-1:0] fix_quotient(input logic [PROD_W-1:0] prod,
                                                     input logic [DEV_W-1:0]  est);
      logic [PROD_W:0] rem;
      rem = {1'b0, prod} - ((PROD_W+1)'(est) * (PROD_W+1)'(100));
      return (rem >= (PROD_W+1)'(100)) ? est + 1'b1 : est;
   endfunction

   function automatic logic [TIME_W-1:0] low_bound(input logic [TIME_W-1:0] t,
                                                   input logic [DEV_W-1:0]  d);
      return ({1'b0, t} > d) ? TIME_W'({1'b0, t} - d) : '0;
   endfunction

   assign wr_en     = csr_valid && csr_ready;
   assign csr_ready = (busy_cnt_ff == '0);
   assign busy      = (busy_cnt_ff != '0);

   assign mul_s = MUL_W'(prod_s_ff) * MUL_W'(DIV_MUL);
   assign mul_l = MUL_W'(prod_l_ff) * MUL_W'(DIV_MUL);
   assign dev_s = fix_quotient(prod_s_ff, est_s_ff);
   assign dev_l = fix_quotient(prod_l_ff, est_l_ff);

   always_comb begin
      busy_cnt_in = busy_cnt_ff;
      window_in   = window_ff;
      if (wr_en) begin
         busy_cnt_in = 2'd3;
      end else if (busy_cnt_ff != '0) begin
         busy_cnt_in = busy_cnt_ff - 1'b1;
      end
      // At busy count one the estimate registers hold the new deviations; this closes the window pipeline.
      if (busy_cnt_ff == 2'd1) begin
         window_in.short_lo = low_bound(short_ff, dev_s);
         window_in.short_hi = HI_W'(short_ff) + HI_W'(dev_s);
         window_in.long_lo  = low_bound(long_ff, dev_l);
         window_in.long_hi  = HI_W'(long_ff) + HI_W'(dev_l);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff           <= SHORT_TIME_RST;
         long_ff            <= LONG_TIME_RST;
         pct_ff             <= PCT_RST;
         req_bits_ff        <= REQ_BITS_RST;
         min_valid_ff       <= MIN_VALID_RST;
         min_len_ff         <= MIN_LEN_RST;
         busy_cnt_ff        <= '0;
         window_ff.short_lo <= SHORT_LO_RST;
         window_ff.short_hi <= SHORT_HI_RST;
         window_ff.long_lo  <= LONG_LO_RST;
         window_ff.long_hi  <= LONG_HI_RST;
      end else begin
         busy_cnt_ff <= busy_cnt_in;
         window_ff   <= window_in;
         if (wr_en) begin
            unique case (csr_index)
               CSR_SHORT_TIME: short_ff     <= csr_data;
               CSR_LONG_TIME:  long_ff      <= csr_data;
               CSR_TOL_PCT:    pct_ff       <= csr_data[PCT_W-1:0];
               CSR_REQ_BITS:   req_bits_ff  <= csr_data[BITS_W-1:0];
               CSR_MIN_VALID:  min_valid_ff <= csr_data[BITS_W-1:0];
               CSR_MIN_LEN:    min_len_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_s_ff <= PROD_W'(short_ff) * PROD_W'(pct_ff);
      prod_l_ff <= PROD_W'(long_ff) * PROD_W'(pct_ff);
      est_s_ff  <= DEV_W'(mul_s >> DIV_SHIFT);
      est_l_ff  <= DEV_W'(mul_l >> DIV_SHIFT);
   end

   assign window               = window_ff;
   assign decode_cfg.req_bits  = req_bits_ff;
   assign decode_cfg.min_valid = min_valid_ff;
   assign min_len              = min_len_ff;

endmodule

// ===== rtl/ookd_front.sv =====
module ookd_front
   import ookd_pkg::*;
#(
   parameter int DURATION_WIDTH = DURATION_WIDTH_DEF
) (
   input  logic signed [DURATION_WIDTH-1:0] duration,
   input  logic                             first_of_capture,
   input  logic                             last_of_capture,
   input  logic [LEN_W-1:0]                 capture_length,
   input  window_type                       window,
   input  logic [LEN_W-1:0]                 min_len,
   output item_type                         item
);

   localparam int CMP_W = (DURATION_WIDTH > HI_W) ? DURATION_WIDTH : HI_W;

   logic [DURATION_WIDTH-1:0] mag;
   logic [CMP_W-1:0]          mag_x;

   // The most negative value maps to its true magnitude as an unsigned word.
   assign mag   = duration[DURATION_WIDTH-1] ? (~duration + 1'b1) : duration;
   assign mag_x = CMP_W'(mag);

   always_comb begin
      item.first     = first_of_capture;
      item.last      = last_of_capture;
      item.neg       = duration[DURATION_WIDTH-1];
      item.too_short = (capture_length < min_len);
      item.in_short  = (mag_x >= CMP_W'(window.short_lo)) && (mag_x <= CMP_W'(window.short_hi));
      item.in_long   = (mag_x >= CMP_W'(window.long_lo)) && (mag_x <= CMP_W'(window.long_hi));
   end

endmodule

// ===== rtl/ookd_back.sv =====
module ookd_back
   import ookd_pkg::*;
#(
   parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  decode_cfg_type decode_cfg,
   input  item_type       item,
   input  logic           item_empty,
   output logic           item_pop,
   input  logic           result_full,
   output logic           result_push,
   output result_type     result
);

   localparam logic [BITS_W-1:0] CNT_MAX = '1;

   logic                     expect_gap_ff, expect_gap_in;
   logic                     held_short_ff, held_short_in;
   logic                     held_long_ff, held_long_in;
   logic [MAX_CODE_BITS-1:0] code_ff, code_in;
   logic [BITS_W-1:0]        cnt_ff, cnt_in;
   logic                     finished_ff, finished_in;

   logic                     take, run, emit;
   status_type               emit_status;
   logic                     cur_gap;
   logic [MAX_CODE_BITS-1:0] cur_code, new_code;
   logic [BITS_W-1:0]        cur_cnt, new_cnt;
   logic                     bit0, bit1;
   logic [63:0]              code_wide;

   assign take     = !item_empty && !result_full;
   assign item_pop = take;

   // A first word starts from a cleared decoder.
   assign cur_gap  = item.first ? 1'b0 : expect_gap_ff;
   assign cur_code = item.first ? '0 : code_ff;
   assign cur_cnt  = item.first ? '0 : cnt_ff;
   assign bit0     = held_short_ff && item.in_long;
   assign bit1     = held_long_ff && item.in_short;
   assign new_code = {cur_code[MAX_CODE_BITS-2:0], !bit0};
   assign new_cnt  = (cur_cnt == CNT_MAX) ? CNT_MAX : cur_cnt + 1'b1;
   assign code_wide = 64'(new_code);

   always_comb begin
      expect_gap_in = expect_gap_ff;
      held_short_in = held_short_ff;
      held_long_in  = held_long_ff;
      code_in       = code_ff;
      cnt_in        = cnt_ff;
      finished_in   = finished_ff;
      run           = 1'b0;
      emit          = 1'b0;
      emit_status   = STATUS_ENDED;
      if (take) begin
         if (item.first) begin
            expect_gap_in = 1'b0;
            code_in       = '0;
            cnt_in        = '0;
            finished_in   = 1'b0;
            if (item.too_short) begin
               emit        = 1'b1;
               emit_status = STATUS_SHORT;
            end else if (item.neg) begin
               // A leading gap is skipped unless it is also the last word.
               emit        = item.last;
               emit_status = STATUS_ENDED;
            end else begin
               run = 1'b1;
            end
         end else begin
            run = !finished_ff;
         end

         if (run) begin
            if (!cur_gap) begin
               if (item.neg) begin
                  emit        = 1'b1;
                  emit_status = STATUS_NEGPULSE;
               end else begin
                  held_short_in = item.in_short;
                  held_long_in  = item.in_long;
                  expect_gap_in = 1'b1;
               end
            end else begin
               expect_gap_in = 1'b0;
               if (!bit0 && !bit1) begin
                  if (cur_cnt >= decode_cfg.min_valid) begin
                     emit        = 1'b1;
                     emit_status = STATUS_BROKEN;
                  end else begin
                     code_in = '0;
                     cnt_in  = '0;
                  end
               end else begin
                  code_in = new_code;
                  cnt_in  = new_cnt;
                  if (new_cnt == decode_cfg.req_bits) begin
                     emit        = 1'b1;
                     emit_status = STATUS_OK;
                  end
               end
            end
            if (!emit && item.last) begin
               emit        = 1'b1;
               emit_status = STATUS_ENDED;
            end
         end

         if (emit) begin
            finished_in = 1'b1;
         end
      end
   end

   always_comb begin
      result_push   = emit;
      result.ok     = (emit_status == STATUS_OK);
      result.status = emit_status;
      result.code   = (emit_status == STATUS_OK) ? code_wide[CODE_W-1:0] : '0;
      result.bits   = (emit_status == STATUS_OK) ? new_cnt : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_gap_ff <= 1'b0;
         held_short_ff <= 1'b0;
         held_long_ff  <= 1'b0;
         code_ff       <= '0;
         cnt_ff        <= '0;
         finished_ff   <= 1'b1;
      end else begin
         expect_gap_ff <= expect_gap_in;
         held_short_ff <= held_short_in;
         held_long_ff  <= held_long_in;
         code_ff       <= code_in;
         cnt_ff        <= cnt_in;
         finished_ff   <= finished_in;
      end
   end

endmodule

// ===== rtl/ook_pwm_fixed_code_decoder.sv =====
// OOK pulse-width fixed-code decoder.
// Input queue: write a signed duration with req_push while req_full is low; mark the
// first word of a capture with req_first_of_capture (req_capture_length is read then)
// and the final one with req_last_of_capture. Each capture yields one status word.
// Result queue: while rsp_empty is low the oldest status word is on the rsp_ ports;
// rsp_pop takes it.
// Configuration: csr_valid/csr_ready write csr_data to register csr_index. After each
// write the tolerance windows are recomputed in the product, estimate and window
// registers; csr_ready stays low and req_full stays high for that time.
// A word reaches the rsp_ ports through the input queue and then the result queue.
// Throughput: one duration per cycle while req_full is low; a front stage classifies
// each duration against the windows, a two-word queue hands it to the decode stage,
// which handles one word a cycle into a two-word result queue while that is not full.
// Reset: both queues empty, registers at their defaults, the decoder idle until a first
// word. When the receiver stops popping, the result queue fills, the decoder stops and
// the input queue fills behind it; req_full goes high and no word is lost.
module ook_pwm_fixed_code_decoder
   import ookd_pkg::*;
#(
   parameter int DURATION_WIDTH = DURATION_WIDTH_DEF,
   parameter int MAX_CODE_BITS  = MAX_CODE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic signed [DURATION_WIDTH-1:0] req_duration,
   input  logic                             req_first_of_capture,
   input  logic                             req_last_of_capture,
   input  logic [LEN_W-1:0]                 req_capture_length,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic                             rsp_decoded_ok,
   output logic [STAT_W-1:0]                rsp_status,
   output logic [CODE_W-1:0]                rsp_code,
   output logic [BITS_W-1:0]                rsp_bits_decoded,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [IDX_W-1:0]                 csr_index,
   input  logic [TIME_W-1:0]                csr_data
);

   window_type     window;
   decode_cfg_type decode_cfg;
   logic [LEN_W-1:0] min_len;
   logic           csr_busy;
   item_type       front_item, back_item;
   logic           item_full, item_empty, item_pop;
   logic           result_full, result_push;
   result_type     back_result, rsp_result;

   ookd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .window     (window),
      .decode_cfg (decode_cfg),
      .min_len    (min_len),
      .busy       (csr_busy)
   );

   ookd_front #(
      .DURATION_WIDTH (DURATION_WIDTH)
   ) u_front (
      .duration         (req_duration),
      .first_of_capture (req_first_of_capture),
      .last_of_capture  (req_last_of_capture),
      .capture_length   (req_capture_length),
      .window           (window),
      .min_len          (min_len),
      .item             (front_item)
   );

   assign req_full = item_full || csr_busy;

   ookd_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push && !csr_busy),
      .wr_data (front_item),
      .full    (item_full),
      .pop     (item_pop),
      .rd_data (back_item),
      .empty   (item_empty)
   );

   ookd_back #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .decode_cfg  (decode_cfg),
      .item        (back_item),
      .item_empty  (item_empty),
      .item_pop    (item_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result      (back_result)
   );

   ookd_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_q (
      .clock   (clock),
      .reset   (reset),
      .push    (result_push),
      .wr_data (back_result),
      .full    (result_full),
      .pop     (rsp_pop),
      .rd_data (rsp_result),
      .empty   (rsp_empty)
   );

   assign rsp_decoded_ok   = rsp_result.ok;
   assign rsp_status       = rsp_result.status;
   assign rsp_code         = rsp_result.code;
   assign rsp_bits_decoded = rsp_result.bits;

endmodule

// ===== rtl/ookd_checker.sv =====
module ookd_checker
   import ookd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input logic              rsp_decoded_ok,
   input logic [STAT_W-1:0] rsp_status,
   input logic [CODE_W-1:0] rsp_code,
   input logic [BITS_W-1:0] rsp_bits_decoded,
   input logic              csr_valid,
   input logic              csr_ready
);

   // The result queue is empty right after reset.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // A register write holds off input while the windows are recomputed.
   assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (req_full && !csr_ready))
      else $error("input accepted during window recompute");

   // The success flag agrees with the status code.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_decoded_ok == (rsp_status == STATUS_OK)))
      else $error("decoded_ok disagrees with status");

   // Failure words carry no code bits.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_decoded_ok) |-> (rsp_code == '0 && rsp_bits_decoded == '0))
      else $error("failure word carries code bits");

   // A waiting word stays put until it is popped.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_code) && $stable(rsp_status)))
      else $error("waiting result word changed");

endmodule

bind ook_pwm_fixed_code_decoder ookd_checker u_ookd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_decoded_ok   (rsp_decoded_ok),
   .rsp_status       (rsp_status),
   .rsp_code         (rsp_code),
   .rsp_bits_decoded (rsp_bits_decoded),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready)
);
